[rtl/core/rlcseg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// RLC UM transmit segmenter package
// Shared payload structs, codes and a helper function of the segmenter.
// ----------------------------------------------------------------------------
package rlcseg_pkg;

  localparam int unsigned SnW      = 12;
  localparam int unsigned ModW     = 13;
  localparam int unsigned CfgDataW = 13;
  localparam logic [ModW-1:0] ModMax   = 13'd4096;
  localparam logic [ModW-1:0] ModReset = 13'd64;

  // Header lengths of the different PDU kinds.
  localparam logic [2:0] HdrLenFull      = 3'd1;
  localparam logic [2:0] HdrLenFirst6    = 3'd1;
  localparam logic [2:0] HdrLenFirst12   = 3'd2;
  localparam logic [2:0] HdrLenSeg6      = 3'd3;
  localparam logic [2:0] HdrLenSeg12     = 3'd4;

  typedef enum logic [1:0] {
    ST_BUILT   = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_NOTHING = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SI_FULL   = 2'd0,
    SI_FIRST  = 2'd1,
    SI_LAST   = 2'd2,
    SI_MIDDLE = 2'd3
  } seg_info_e;

  typedef enum logic {
    CFG_SN_TWELVE  = 1'b0,
    CFG_SN_MODULUS = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] grant_bytes;
    logic        sdu_available;
    logic [15:0] sdu_length;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic        sdu_taken;
    seg_info_e   seg_info;
    logic [11:0] seq_number;
    logic [15:0] seg_offset;
    logic [2:0]  hdr_len;
    logic [15:0] payload_bytes;
    logic [15:0] pdu_bytes;
    logic [7:0]  hdr_byte0;
    logic [7:0]  hdr_byte1;
    logic [7:0]  hdr_byte2;
    logic [7:0]  hdr_byte3;
  } out_item_t;

  typedef struct packed {
    logic            sn_twelve_bit;
    logic [ModW-1:0] sn_modulus;
  } cfg_t;

  typedef struct packed {
    logic            start;
    logic [ModW-1:0] dividend;
    logic [ModW-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [SnW-1:0] remainder;
  } mod_rsp_t;

  typedef struct packed {
    logic        sn_twelve_bit;
    seg_info_e   seg_info;
    logic [11:0] seq_number;
    logic [15:0] seg_offset;
  } hdr_req_t;

  // A modulus of zero or above the largest legal value is taken as the largest.
  function automatic logic [ModW-1:0] eff_modulus(logic [ModW-1:0] raw);
    logic [ModW-1:0] m;
    m = ((raw == '0) || (raw > ModMax)) ? ModMax : raw;
    return m;
  endfunction

endpackage
`default_nettype wire

[rtl/core/rlcseg_mod_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Sequence number remainder unit
// Restoring remainder, one dividend bit per cycle, for SN reduction.
// ----------------------------------------------------------------------------
module rlcseg_mod_unit
  import rlcseg_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire mod_req_t req_i,
  output mod_rsp_t      rsp_o
);

  logic           busy_q, busy_d;
  logic [3:0]     cnt_q, cnt_d;
  logic [SnW-1:0] rem_q, rem_d;
  logic [ModW-1:0] dvd_q, dvd_d;
  logic [ModW-1:0] dvs_q, dvs_d;
  logic [ModW-1:0] trial;
  logic           last_step;

  assign trial     = {rem_q, dvd_q[ModW-1]};
  assign last_step = busy_q && (cnt_q == 4'd0);

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 4'(ModW - 1);
      rem_d  = '0;
      dvd_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // The partial remainder stays below the divisor, so it fits in SnW bits.
      rem_d = (trial >= dvs_q) ? SnW'(trial - dvs_q) : SnW'(trial);
      dvd_d = {dvd_q[ModW-2:0], 1'b0};
      cnt_d = cnt_q - 4'd1;
      if (cnt_q == 4'd0) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = last_step && !req_i.start;
  assign rsp_o.remainder = rem_d;

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (cnt_q <= 4'(ModW - 1)))
    else $error("remainder step counter out of range");

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> ({1'b0, rem_q} < dvs_q))
    else $error("partial remainder not below divisor");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |=> busy_q)
    else $error("remainder unit not busy after start");

endmodule
`default_nettype wire

[rtl/core/rlcseg_hdr_pack.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Header byte packer
// Packs SI, SN and SO into up to four UM header bytes.
// ----------------------------------------------------------------------------
module rlcseg_hdr_pack
  import rlcseg_pkg::*;
(
  input  wire hdr_req_t    req_i,
  output logic [3:0][7:0]  bytes_o
);

  logic has_so;

  always_comb begin
    bytes_o = '0;
    has_so  = (req_i.seg_info == SI_LAST) || (req_i.seg_info == SI_MIDDLE);
    if (req_i.seg_info != SI_FULL) begin
      if (req_i.sn_twelve_bit) begin
        bytes_o[0] = {req_i.seg_info, 2'b00, req_i.seq_number[11:8]};
        bytes_o[1] = req_i.seq_number[7:0];
        if (has_so) begin
          bytes_o[2] = req_i.seg_offset[15:8];
          bytes_o[3] = req_i.seg_offset[7:0];
        end
      end else begin
        bytes_o[0] = {req_i.seg_info, req_i.seq_number[5:0]};
        if (has_so) begin
          bytes_o[1] = req_i.seg_offset[15:8];
          bytes_o[2] = req_i.seg_offset[7:0];
        end
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/rlcseg_seg_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// Segmentation decision and SDU state
// Chooses the PDU kind for one transmit opportunity and updates SN/SO state.
// ----------------------------------------------------------------------------
module rlcseg_seg_ctrl
  import rlcseg_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      fire_i,
  input  wire in_item_t  item_i,
  input  wire cfg_t      cfg_i,
  input  wire mod_rsp_t  mod_rsp_i,
  output logic [SnW-1:0] sn_o,
  output out_item_t      res_o
);

  logic [SnW-1:0] sn_q, sn_d;
  logic [SnW-1:0] nxt_sn_q, nxt_sn_d;
  logic [15:0]    off_q, off_d;
  logic [15:0]    rem_q, rem_d;
  logic           pend_q, pend_d;

  logic [SnW-1:0] cur_sn;
  logic [2:0]     hl_seg;
  logic [2:0]     hl_first;
  logic [15:0]    space;
  logic [15:0]    seg_pay;
  logic [15:0]    rem_after;
  logic [ModW-1:0] nxt_inc;
  logic           full_fits;
  logic           seg_fits;
  logic           first_fits;
  hdr_req_t       hdr_req;
  logic [3:0][7:0] hdr_bytes;
  out_item_t      res;
  logic           advance_sn;

  assign cur_sn   = cfg_i.sn_twelve_bit ? sn_q : {6'd0, sn_q[5:0]};
  assign hl_seg   = cfg_i.sn_twelve_bit ? HdrLenSeg12 : HdrLenSeg6;
  assign hl_first = cfg_i.sn_twelve_bit ? HdrLenFirst12 : HdrLenFirst6;

  assign seg_fits   = {1'b0, item_i.grant_bytes} > (17'(hl_seg) + 17'd1);
  assign first_fits = {1'b0, item_i.grant_bytes} > (17'(hl_first) + 17'd1);
  assign full_fits  = (item_i.grant_bytes > 16'd2) &&
                      ({1'b0, item_i.grant_bytes} >= ({1'b0, item_i.sdu_length} + 17'd1));

  assign space     = item_i.grant_bytes - 16'(hl_seg);
  assign seg_pay   = (rem_q <= space) ? rem_q : space;
  assign rem_after = rem_q - seg_pay;

  // Stored next SN is already reduced, so the following one needs one compare.
  assign nxt_inc = {1'b0, nxt_sn_q} + 13'd1;

  always_comb begin
    res            = '0;
    res.status     = ST_BUILT;
    res.seg_info   = SI_FULL;
    pend_d         = pend_q;
    rem_d          = rem_q;
    off_d          = off_q;
    advance_sn     = 1'b0;
    if (pend_q) begin
      if (seg_fits) begin
        res.hdr_len       = hl_seg;
        res.payload_bytes = seg_pay;
        res.seg_offset    = off_q;
        res.seq_number    = cur_sn;
        rem_d             = rem_after;
        if (rem_after == 16'd0) begin
          res.seg_info = SI_LAST;
          pend_d       = 1'b0;
          off_d        = '0;
          advance_sn   = 1'b1;
        end else begin
          res.seg_info = SI_MIDDLE;
          off_d        = off_q + seg_pay;
        end
      end else begin
        res.status = ST_NO_ROOM;
      end
    end else if (!item_i.sdu_available) begin
      res.status = ST_NOTHING;
    end else if (full_fits) begin
      res.hdr_len       = HdrLenFull;
      res.payload_bytes = item_i.sdu_length;
      res.sdu_taken     = 1'b1;
      off_d             = '0;
    end else if (first_fits) begin
      res.hdr_len       = hl_first;
      res.payload_bytes = item_i.grant_bytes - 16'(hl_first);
      res.seg_info      = SI_FIRST;
      res.seq_number    = cur_sn;
      res.sdu_taken     = 1'b1;
      rem_d             = item_i.sdu_length - res.payload_bytes;
      pend_d            = 1'b1;
      off_d             = res.payload_bytes;
    end else begin
      res.status = ST_NO_ROOM;
    end
    res.pdu_bytes = 16'(res.hdr_len) + res.payload_bytes;

    hdr_req.sn_twelve_bit = cfg_i.sn_twelve_bit;
    hdr_req.seg_info      = res.seg_info;
    hdr_req.seq_number    = res.seq_number;
    hdr_req.seg_offset    = res.seg_offset;
  end

  rlcseg_hdr_pack u_hdr_pack (
    .req_i   (hdr_req),
    .bytes_o (hdr_bytes)
  );

  always_comb begin
    res_o           = res;
    res_o.hdr_byte0 = hdr_bytes[0];
    res_o.hdr_byte1 = hdr_bytes[1];
    res_o.hdr_byte2 = hdr_bytes[2];
    res_o.hdr_byte3 = hdr_bytes[3];
  end

  always_comb begin
    sn_d     = sn_q;
    nxt_sn_d = nxt_sn_q;
    if (mod_rsp_i.done) begin
      nxt_sn_d = mod_rsp_i.remainder;
    end else if (fire_i && advance_sn) begin
      sn_d     = nxt_sn_q;
      nxt_sn_d = (nxt_inc == cfg_i.sn_modulus) ? '0 : SnW'(nxt_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sn_q     <= '0;
      nxt_sn_q <= SnW'(1);
      off_q    <= '0;
      rem_q    <= '0;
      pend_q   <= 1'b0;
    end else begin
      sn_q     <= sn_d;
      nxt_sn_q <= nxt_sn_d;
      if (fire_i) begin
        off_q  <= off_d;
        rem_q  <= rem_d;
        pend_q <= pend_d;
      end
    end
  end

  assign sn_o = sn_q;

endmodule
`default_nettype wire

[rtl/core/rlc_um_tx_segmenter_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// RLC UM transmit segmenter
// One transmit opportunity in, one PDU decision with packed header out.
// ----------------------------------------------------------------------------
// Each transfer on the input channel is one transmit opportunity. The block
// decides between a whole SDU, a first, a middle or a last segment, or
// reports that the grant is too small or that nothing is queued, and returns
// exactly one result per opportunity. An opportunity is registered on entry,
// decided by short compare-and-subtract logic and held in an output
// register, so a new opportunity is taken in every cycle while the output
// side does not stall. The one exception is a write of the SN modulus: the
// stored next sequence number is then reduced by a bit-serial remainder
// unit, and the input channel stalls while that unit is busy. Configuration
// is meant to be written only while the block is idle.
// ----------------------------------------------------------------------------
module rlc_um_tx_segmenter_unit
  import rlcseg_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Configuration write port
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  // Transmit opportunity channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire in_item_t            in_data_i,
  // Result channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output out_item_t                out_data_o
);

  // Configuration registers. The modulus is kept as written; its
  // effective value is worked out combinationally.
  logic            twelve_q;
  logic [ModW-1:0] modulus_q;
  cfg_t            cfg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      twelve_q  <= 1'b0;
      modulus_q <= ModReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SN_TWELVE:  twelve_q  <= cfg_wdata_i[0];
        CFG_SN_MODULUS: modulus_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg.sn_twelve_bit = twelve_q;
  assign cfg.sn_modulus    = eff_modulus(modulus_q);

  // A new modulus can leave the stored next SN above the modulus, so the
  // successor of the current SN is fully reduced by the remainder unit.
  logic [SnW-1:0] cur_sn;
  mod_req_t       mod_req;
  mod_rsp_t       mod_rsp;

  assign mod_req.start    = cfg_we_i && (cfg_idx_e'(cfg_idx_i) == CFG_SN_MODULUS);
  assign mod_req.dividend = {1'b0, cur_sn} + 13'd1;
  assign mod_req.divisor  = eff_modulus(cfg_wdata_i);

  rlcseg_mod_unit u_mod_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // Input register stage.
  logic      s1_valid_q;
  in_item_t  s1_data_q;
  logic      in_xfer;
  logic      out_free;
  logic      fire;

  // The output register can take a result when it is empty or being drained.
  assign out_free   = !out_valid_o || !out_stall_i;
  assign fire       = s1_valid_q && out_free && !mod_rsp.busy;
  assign in_stall_o = mod_rsp.busy || (s1_valid_q && !fire);
  assign in_xfer    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_data_q <= in_data_i;
    end
  end

  // Decision logic with the SDU state; state moves only when a result is
  // written to the output register; the remainder unit also sets the next SN.
  out_item_t res;

  rlcseg_seg_ctrl u_seg_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .item_i    (s1_data_q),
    .cfg_i     (cfg),
    .mod_rsp_i (mod_rsp),
    .sn_o      (cur_sn),
    .res_o     (res)
  );

  // Output register stage.
  logic      out_valid_q;
  out_item_t out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  a_no_fire_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_rsp.busy |-> !fire)
    else $error("decision taken while the SN remainder is being reduced");

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("decided opportunity did not reach the output register");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !fire)
    else $error("stalled result overwritten");

endmodule
`default_nettype wire
